@@ hw/rtl/adc_averaging_sequencer_core_macros.svh @@
// Assertion macros shared by the averaging sequencer RTL.
`ifndef ADC_AVERAGING_SEQUENCER_CORE_MACROS_SVH
`define ADC_AVERAGING_SEQUENCER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define AVS_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define AVS_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define AVS_ASSERT_IMP(lbl, ck, rs, ante, cons)
`define AVS_ASSERT_NXT(lbl, ck, rs, ante, cons)
`endif

`endif

@@ hw/rtl/adcav_pkg.sv @@
// Types, constants and helper functions of the averaging sequencer.
package adcav_pkg;

  localparam int CHANNELS_DEF    = 4;
  localparam int SAMPLE_BITS_DEF = 10;

  localparam int SAMPLE_W = 10;
  localparam int SUM_W    = 24;
  localparam int CNT_W    = 8;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;

  localparam logic       CMD_READ      = 1'b0;
  localparam logic       KIND_CONV     = 1'b0;
  localparam logic       KIND_READING  = 1'b1;
  localparam logic [1:0] PM_OFF        = 2'd1;
  localparam logic [1:0] PM_AUTO       = 2'd2;
  localparam logic [1:0] PWR_NONE      = 2'd0;
  localparam logic [1:0] PWR_UP        = 2'd1;
  localparam logic [1:0] PWR_DOWN      = 2'd2;
  localparam logic [3:0] RES_MAX       = 4'd10;
  localparam logic [15:0] TIMEOUT_VALUE = 16'hffff;
  localparam logic [15:0] RES_TABLE_RST = 16'haaaa;

  typedef enum logic [2:0] {
    REG_CHANNEL    = 3'd0,
    REG_POWER_MODE = 3'd1,
    REG_RES_TABLE  = 3'd2,
    REG_AVG0       = 3'd3
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]  channel;
    logic [1:0]  power_mode;
    logic [15:0] res_table;
  } cfg_t;

  typedef struct packed {
    logic        kind;
    logic [1:0]  channel;
    logic [3:0]  resolution;
    logic [1:0]  power;
    logic [15:0] reading;
    logic        status;
  } res_t;

  // Resolution nibble of a channel; zero or anything above ten acts as ten.
  function automatic logic [3:0] res_of(input logic [15:0] tbl, input logic [1:0] ch);
    logic [3:0] r;
    r = tbl[{ch, 2'b00} +: 4];
    if (r == 4'd0 || r > RES_MAX) r = RES_MAX;
    return r;
  endfunction

endpackage

@@ hw/rtl/adcav_cfg.sv @@
// APB register file holding channel, power mode, resolutions and averaging counts.
module adcav_cfg #(
  parameter int CHANNELS = adcav_pkg::CHANNELS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [adcav_pkg::ADDR_W-1:0] paddr,
  input  logic [adcav_pkg::DATA_W-1:0] pwdata,
  output logic [adcav_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output adcav_pkg::cfg_t            cfg,
  output logic [adcav_pkg::CNT_W-1:0] avg_count [CHANNELS]
);
  import adcav_pkg::*;

  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.channel    <= 2'd0;
      cfg.power_mode <= PM_AUTO;
      cfg.res_table  <= RES_TABLE_RST;
      for (int c = 0; c < CHANNELS; c++) avg_count[c] <= '0;
    end else if (wr_en) begin
      if (idx == REG_CHANNEL)    cfg.channel    <= pwdata[1:0];
      if (idx == REG_POWER_MODE) cfg.power_mode <= pwdata[1:0];
      if (idx == REG_RES_TABLE)  cfg.res_table  <= pwdata[15:0];
      for (int c = 0; c < CHANNELS; c++) begin
        if (idx == reg_idx_t'(3'(int'(REG_AVG0) + c))) avg_count[c] <= pwdata[CNT_W-1:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (idx == REG_CHANNEL)    prdata = DATA_W'(cfg.channel);
    if (idx == REG_POWER_MODE) prdata = DATA_W'(cfg.power_mode);
    if (idx == REG_RES_TABLE)  prdata = DATA_W'(cfg.res_table);
    for (int c = 0; c < CHANNELS; c++) begin
      if (idx == reg_idx_t'(3'(int'(REG_AVG0) + c))) prdata = DATA_W'(avg_count[c]);
    end
  end

endmodule

@@ hw/rtl/adcav_div.sv @@
// Restoring divider: one quotient bit per cycle through a single subtract/compare.
module adcav_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [adcav_pkg::SUM_W-1:0] dividend,
  input  logic [adcav_pkg::CNT_W-1:0] divisor,
  output logic                        done,
  output logic [adcav_pkg::SUM_W-1:0] quotient
);
  import adcav_pkg::*;

  localparam int CntW = $clog2(SUM_W);
  localparam logic [CntW-1:0] LastStep = CntW'(SUM_W - 1);

  logic             busy;
  logic [CntW-1:0]  cnt;
  logic [CNT_W-1:0] rem;
  logic [CNT_W-1:0] dvs;
  logic [CNT_W:0]   trial;
  logic [CNT_W:0]   diff;
  logic             ge;

  assign trial = {rem, quotient[SUM_W-1]};
  assign ge    = trial >= {1'b0, dvs};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == LastStep);
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LastStep) busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (busy) begin
      // The remainder stays below the divisor, so it always fits the divisor width.
      rem      <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      quotient <= {quotient[SUM_W-2:0], ge};
    end
  end

`include "adc_averaging_sequencer_core_macros.svh"
  `AVS_ASSERT_NXT(a_div_start, clk, rst, start, busy)
  `AVS_ASSERT_IMP(a_div_cnt, clk, rst, busy, cnt <= LastStep)
  `AVS_ASSERT_IMP(a_div_done, clk, rst, done, !busy)

endmodule

@@ hw/rtl/adc_averaging_sequencer_core.sv @@
// Averaging conversion sequencer: request handling, sample accumulation, result output.
//
// Input stream (s_*): tuser 0 is a read request, tuser 1 a finished conversion
// carrying its sample and a timeout flag in tdata. Output stream (m_*): tuser 0
// is a start-conversion command, tuser 1 the final reading.
// Each accepted transaction is latched, then evaluated; a request, an
// intermediate sample or a converter-off answer then moves into the output
// register. The sample that completes an average first runs the 24-step
// restoring divider, one quotient bit a cycle, before its reading moves there.
// s_tready is high only while the sequencer sits idle, so items are taken one
// at a time.
// One output register separates the sides: a finished result waits there
// while the next transaction is accepted; if it is still not taken when the
// next result is ready, the sequencer holds that result until it is.
// Reset (synchronous, active high) returns the block to idle with no request
// in progress, no pending result, and the registers at their reset values.
// APB writes apply at once; a running sequence keeps its channel, resolution and count.
module adc_averaging_sequencer_core #(
  parameter int CHANNELS    = adcav_pkg::CHANNELS_DEF,
  parameter int SAMPLE_BITS = adcav_pkg::SAMPLE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // APB configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [adcav_pkg::ADDR_W-1:0] paddr,
  input  logic [adcav_pkg::DATA_W-1:0] pwdata,
  output logic [adcav_pkg::DATA_W-1:0] prdata,
  output logic                         pready,
  // Input stream
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [15:0]                  s_tdata,  // sample[9:0], timed_out[10], zero[15:11]
  input  logic                         s_tuser,  // cmd[0]
  // Output stream
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // conv_channel[1:0], conv_resolution[5:2], power_request[7:6], reading[23:8],
  // status[24], zero[31:25]
  output logic [31:0]                  m_tdata,
  output logic                         m_tuser   // kind[0]
);
  import adcav_pkg::*;

  localparam int MaskBits = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
  localparam logic [SAMPLE_W-1:0] SampleMask = SAMPLE_W'((1 << MaskBits) - 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_PROC = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t state;

  cfg_t             cfg;
  logic [CNT_W-1:0] avg_count [CHANNELS];

  logic                in_cmd;
  logic [SAMPLE_W-1:0] in_sample;
  logic                in_timeout;

  logic             busy;
  logic [CNT_W-1:0] remaining;
  logic [CNT_W-1:0] divisor;
  logic [SUM_W-1:0] sum;
  logic [1:0]       act_ch;
  logic [3:0]       act_res;

  logic [1:0]       eff_ch;
  logic [CNT_W-1:0] sel_avg;
  logic [15:0]      add_val;
  logic [SUM_W-1:0] sum_add;
  logic [CNT_W-1:0] rem_dec;
  logic [CNT_W-1:0] div_by;
  logic             is_auto;

  res_t proc_res;
  logic proc_emit;
  logic proc_load;
  logic proc_step;
  logic proc_start;
  res_t res_hold;
  res_t out_res;
  res_t div_res;
  logic out_load;

  logic             div_done;
  logic [SUM_W-1:0] div_q;

  adcav_cfg #(.CHANNELS(CHANNELS)) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .cfg      (cfg),
    .avg_count(avg_count)
  );

  adcav_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (proc_start),
    .dividend(sum_add),
    .divisor (div_by),
    .done    (div_done),
    .quotient(div_q)
  );

  assign s_tready = (state == ST_IDLE);
  assign is_auto  = (cfg.power_mode >= PM_AUTO);
  assign eff_ch   = (3'(cfg.channel) < 3'(CHANNELS)) ? cfg.channel : 2'd0;
  assign div_by   = (divisor == '0) ? CNT_W'(1) : divisor;
  assign add_val  = in_timeout ? TIMEOUT_VALUE : 16'(in_sample & SampleMask);
  assign sum_add  = sum + SUM_W'(add_val);
  assign rem_dec  = remaining - CNT_W'(1);
  assign out_load = (state == ST_EMIT) && (!m_tvalid || m_tready);

  always_comb begin
    sel_avg = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      if (eff_ch == 2'(c)) sel_avg = avg_count[c];
    end
  end

  // Final reading; a quotient beyond 16 bits saturates.
  always_comb begin
    div_res            = '0;
    div_res.kind       = KIND_READING;
    div_res.channel    = act_ch;
    div_res.resolution = act_res;
    div_res.power      = is_auto ? PWR_DOWN : PWR_NONE;
    div_res.reading    = (div_q[SUM_W-1:16] != '0) ? 16'hffff : div_q[15:0];
  end

  always_comb begin
    proc_res   = '0;
    proc_emit  = 1'b0;
    proc_load  = 1'b0;
    proc_step  = 1'b0;
    proc_start = 1'b0;
    if (state == ST_PROC) begin
      if (in_cmd == CMD_READ) begin
        // A request while a sequence runs is dropped.
        if (!busy) begin
          proc_emit          = 1'b1;
          proc_res.channel   = eff_ch;
          proc_res.resolution = res_of(cfg.res_table, eff_ch);
          if (cfg.power_mode == PM_OFF) begin
            proc_res.kind   = KIND_READING;
            proc_res.status = 1'b1;
          end else begin
            proc_load      = 1'b1;
            proc_res.kind  = KIND_CONV;
            proc_res.power = is_auto ? PWR_UP : PWR_NONE;
          end
        end
      end else if (busy) begin
        proc_step = 1'b1;
        if (rem_dec != '0) begin
          proc_emit           = 1'b1;
          proc_res.kind       = KIND_CONV;
          proc_res.channel    = act_ch;
          proc_res.resolution = act_res;
        end else begin
          proc_start = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      busy      <= 1'b0;
      remaining <= '0;
      divisor   <= '0;
      sum       <= '0;
      act_ch    <= 2'd0;
      act_res   <= RES_MAX;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) state <= ST_PROC;
        end
        ST_PROC: begin
          if (proc_load) begin
            act_ch    <= eff_ch;
            act_res   <= res_of(cfg.res_table, eff_ch);
            divisor   <= sel_avg;
            remaining <= (sel_avg == '0) ? CNT_W'(1) : sel_avg;
            sum       <= '0;
            busy      <= 1'b1;
          end
          if (proc_step) begin
            sum       <= sum_add;
            remaining <= rem_dec;
            if (rem_dec == '0) busy <= 1'b0;
          end
          if (proc_emit)       state <= ST_EMIT;
          else if (proc_start) state <= ST_DIV;
          else                 state <= ST_IDLE;
        end
        ST_DIV: begin
          if (div_done) state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_load) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_tvalid) begin
      in_cmd     <= s_tuser;
      in_sample  <= s_tdata[SAMPLE_W-1:0];
      in_timeout <= s_tdata[SAMPLE_W];
    end
    if (proc_emit) res_hold <= proc_res;
    else if (state == ST_DIV && div_done) res_hold <= div_res;
    if (out_load) out_res <= res_hold;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tuser = out_res.kind;
  assign m_tdata = {7'd0, out_res.status, out_res.reading, out_res.power,
                    out_res.resolution, out_res.channel};

`include "adc_averaging_sequencer_core_macros.svh"
  `AVS_ASSERT_IMP(a_busy_remaining, clk, rst, busy, remaining != '0)
  `AVS_ASSERT_IMP(a_res_range, clk, rst, busy, act_res != 4'd0 && act_res <= RES_MAX)
  `AVS_ASSERT_NXT(a_div_to_emit, clk, rst, state == ST_DIV && div_done, state == ST_EMIT)
  `AVS_ASSERT_IMP(a_off_reading, clk, rst, out_load && res_hold.status, res_hold.reading == 16'd0 && res_hold.kind == KIND_READING)

endmodule

@@ tb/tb_adc_averaging_sequencer_core.sv @@
// Stream testbench for the averaging conversion sequencer with a built-in predictor.
module tb_adc_averaging_sequencer_core;
  import adcav_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_ITEMS = 1100;
  localparam logic [1:0] PM_ON       = 2'd0;
  localparam logic [1:0] PM_AUTO_ALT = 2'd3;
  localparam logic       CMD_DONE    = 1'b1;

  typedef struct {
    logic       cmd;
    logic [9:0] sample;
    logic       timed_out;
  } host_event_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [15:0]         s_tdata = '0;
  logic                s_tuser = 1'b0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [31:0]         m_tdata;
  logic                m_tuser;

  adc_averaging_sequencer_core dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always #CLK_HALF clk = ~clk;

  // Register shadow and sequencer state of the predictor.
  logic [1:0]  cfg_channel = 2'd0;
  logic [1:0]  cfg_power = PM_AUTO;
  logic [15:0] cfg_res_table = RES_TABLE_RST;
  logic [7:0]  cfg_avg [4] = '{default: 8'd0};
  logic        seq_busy = 1'b0;
  logic [7:0]  seq_left = 8'd0;
  logic [7:0]  seq_div = 8'd0;
  logic [23:0] seq_sum = 24'd0;
  logic [1:0]  seq_ch = 2'd0;
  logic [3:0]  seq_res = RES_MAX;

  host_event_t host_events[$];
  res_t        predicted_out[$];
  int          mismatches = 0;
  int          results_seen = 0;
  int          cycle_count = 0;
  int          items_made = 0;
  int          idle_pct = 0;
  int          gap_left = 0;
  int          stall_left = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;

  function automatic bit pct(input int p);
    return $urandom_range(0, 99) < p;
  endfunction

  function automatic logic [3:0] channel_resolution(input logic [1:0] ch);
    logic [3:0] nib;
    nib = cfg_res_table[ch*4 +: 4];
    return (nib == 4'd0 || nib > RES_MAX) ? RES_MAX : nib;
  endfunction

  // Advances the sequencer by one transaction; returns 1 when it produces an output.
  function automatic bit sequencer_step(input host_event_t ev, output res_t r);
    logic [15:0] v;
    logic [23:0] q;
    logic [7:0]  d;
    r = '0;
    if (ev.cmd == CMD_READ) begin
      if (seq_busy) return 1'b0;
      r.channel = cfg_channel;
      r.resolution = channel_resolution(cfg_channel);
      if (cfg_power == PM_OFF) begin
        r.kind = KIND_READING;
        r.power = PWR_NONE;
        r.status = 1'b1;
        return 1'b1;
      end
      seq_ch = cfg_channel;
      seq_res = r.resolution;
      seq_div = cfg_avg[cfg_channel];
      seq_left = (seq_div == 8'd0) ? 8'd1 : seq_div;
      seq_sum = '0;
      seq_busy = 1'b1;
      r.kind = KIND_CONV;
      r.power = (cfg_power >= PM_AUTO) ? PWR_UP : PWR_NONE;
      return 1'b1;
    end
    if (!seq_busy) return 1'b0;
    v = ev.timed_out ? TIMEOUT_VALUE : {6'd0, ev.sample};
    seq_sum = seq_sum + {8'd0, v};
    seq_left = seq_left - 8'd1;
    r.channel = seq_ch;
    r.resolution = seq_res;
    if (seq_left != 8'd0) begin
      r.kind = KIND_CONV;
      r.power = PWR_NONE;
      return 1'b1;
    end
    seq_busy = 1'b0;
    d = (seq_div == 8'd0) ? 8'd1 : seq_div;
    q = seq_sum / {16'd0, d};
    r.kind = KIND_READING;
    r.reading = (q > 24'hffff) ? 16'hffff : q[15:0];
    r.power = (cfg_power >= PM_AUTO) ? PWR_DOWN : PWR_NONE;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got, input logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  // Sender: presents queued events, predicts each accepted transaction.
  always @(posedge clk) begin
    host_event_t ev;
    res_t        r;
    bit          took;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      took = s_tvalid && s_tready;
      if (took) begin
        ev = host_events.pop_front();
        if (sequencer_step(ev, r)) predicted_out.push_back(r);
      end
      // A new gap starts only when no event is left hanging on the bus.
      if (gap_left == 0 && (!s_tvalid || took) && pct(idle_pct))
        gap_left = $urandom_range(1, 9);
      if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (host_events.size() > 0) begin
        s_tvalid <= 1'b1;
        s_tuser <= host_events[0].cmd;
        s_tdata <= {5'd0, host_events[0].timed_out, host_events[0].sample};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver ready, with one long hold-off so that the sequencer backs up.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (!hold_done && results_seen >= 150 && host_events.size() > 4) begin
      hold_done = 1'b1;
      hold_left = 299;
      m_tready <= 1'b0;
    end else begin
      if (stall_left == 0 && pct(idle_pct)) stall_left = $urandom_range(1, 9);
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    res_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (predicted_out.size() == 0) begin
        report_mismatch($sformatf("unexpected transaction tuser %0d tdata %h", m_tuser, m_tdata));
      end else begin
        want = predicted_out.pop_front();
        check_field("kind", 16'(m_tuser), 16'(want.kind));
        check_field("conv_channel", 16'(m_tdata[1:0]), 16'(want.channel));
        check_field("conv_resolution", 16'(m_tdata[5:2]), 16'(want.resolution));
        check_field("power_request", 16'(m_tdata[7:6]), 16'(want.power));
        check_field("reading", m_tdata[23:8], want.reading);
        check_field("status", 16'(m_tdata[24]), 16'(want.status));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("adc_averaging_sequencer_core verification failed");
      $finish;
    end
  end

  task automatic write_reg(input reg_idx_t base, input int offs, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'((int'(base) + offs) * 4);
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (base)
      REG_CHANNEL:    cfg_channel = val[1:0];
      REG_POWER_MODE: cfg_power = val[1:0];
      REG_RES_TABLE:  cfg_res_table = val[15:0];
      default:        cfg_avg[offs] = val[7:0];
    endcase
  endtask

  task automatic push_req();
    host_events.push_back('{CMD_READ, 10'($urandom_range(0, 1023)), 1'($urandom_range(0, 1))});
    items_made++;
  endtask

  task automatic push_done(input logic [9:0] sample, input logic timed_out);
    host_events.push_back('{CMD_DONE, sample, timed_out});
    items_made++;
  endtask

  // Waits for every result, then lets an ignored event still in flight settle.
  task automatic wait_drained();
    do @(negedge clk); while (host_events.size() != 0 || predicted_out.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin
    int phase;
    int n;
    int k;
    int r;
    int to_pct;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: automatic power, single conversions, resolution ten.
    push_req();
    push_done(10'h3ff, 1'b0);
    push_done(10'd5, 1'b0);
    push_req();
    push_req();
    push_done(10'h3ff, 1'b1);
    push_req();
    push_done(10'd0, 1'b0);
    wait_drained();

    // A zero nibble acts as ten; always-on power.
    write_reg(REG_CHANNEL, 0, 32'd3);
    write_reg(REG_POWER_MODE, 0, 32'(PM_ON));
    write_reg(REG_RES_TABLE, 0, 32'h0b51);
    write_reg(REG_AVG0, 3, 32'd2);
    push_req();
    push_done(10'h3ff, 1'b0);
    push_done(10'd0, 1'b1);
    wait_drained();

    // Converter off answers at once and stays idle.
    write_reg(REG_CHANNEL, 0, 32'd1);
    write_reg(REG_POWER_MODE, 0, 32'(PM_OFF));
    push_req();
    push_done(10'd7, 1'b0);
    wait_drained();

    // Mode three powers up; switching to always-on mid-request drops the power-down.
    write_reg(REG_CHANNEL, 0, 32'd0);
    write_reg(REG_POWER_MODE, 0, 32'(PM_AUTO_ALT));
    write_reg(REG_AVG0, 0, 32'd3);
    push_req();
    push_done(10'd100, 1'b0);
    wait_drained();
    write_reg(REG_POWER_MODE, 0, 32'(PM_ON));
    push_done(10'd200, 1'b0);
    push_done(10'd301, 1'b0);
    wait_drained();

    // And the other way round: no power-up, but a power-down at the answer.
    write_reg(REG_CHANNEL, 0, 32'd2);
    write_reg(REG_AVG0, 2, 32'd1);
    push_req();
    wait_drained();
    write_reg(REG_POWER_MODE, 0, 32'(PM_AUTO));
    push_done(10'd1000, 1'b0);
    wait_drained();

    items_made = 0;
    phase = 0;
    while (items_made < RANDOM_ITEMS) begin
      phase++;
      to_pct = 10;

      if (phase == 2) begin
        // Longest average, all timed out: the largest possible sum.
        write_reg(REG_POWER_MODE, 0, 32'(PM_AUTO));
        write_reg(REG_AVG0, int'(cfg_channel), 32'd255);
        to_pct = 100;
      end else begin
        if (pct(50)) write_reg(REG_CHANNEL, 0, $urandom_range(0, 3));
        if (pct(50)) begin
          r = $urandom_range(0, 9);
          write_reg(REG_POWER_MODE, 0, 32'((r == 0) ? PM_OFF : (r == 1) ? PM_AUTO_ALT :
                                           (r < 6) ? PM_ON : PM_AUTO));
        end
        if (pct(40)) write_reg(REG_RES_TABLE, 0, $urandom_range(0, 16'hffff));
        for (k = 0; k < 4; k++)
          if (pct(40)) write_reg(REG_AVG0, k, pct(3) ? 32'd255 : $urandom_range(0, 6));
      end

      n = (cfg_avg[cfg_channel] == 8'd0) ? 1 : int'(cfg_avg[cfg_channel]);
      if (cfg_power == PM_OFF) n = 0;

      // The last part of the run goes without idling on either side; a long
      // average counts its whole length toward that part.
      if (items_made + ((n > 16) ? n + 32 : 0) > RANDOM_ITEMS - 200) idle_pct = 0;
      else idle_pct = (phase % 3 == 0) ? 0 : ((phase % 3 == 1) ? 10 : 35);

      repeat ((n > 16) ? 1 : $urandom_range(2, 8)) begin
        r = $urandom_range(0, 99);
        if (r < 80) begin
          push_req();
          for (k = 0; k < n; k++) begin
            if (pct(4)) push_req();
            push_done(10'($urandom_range(0, 1023)), pct(to_pct));
          end
        end else if (r < 90) begin
          // Cut short: the request stays open into the next settings.
          push_req();
          for (k = $urandom_range(1, n + 1); k < n; k++)
            push_done(10'($urandom_range(0, 1023)), pct(to_pct));
        end else if (pct(50)) begin
          push_done(10'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)));
        end else begin
          push_req();
        end
      end
      wait_drained();
    end

    if (mismatches == 0)
      $display("adc_averaging_sequencer_core verification clean");
    else
      $display("adc_averaging_sequencer_core verification failed");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/adcav_pkg.sv
hw/rtl/adcav_cfg.sv
hw/rtl/adcav_div.sv
hw/rtl/adc_averaging_sequencer_core.sv
tb/tb_adc_averaging_sequencer_core.sv
